>>> rtl/rsnh_pkg.sv
`timescale 1ns / 1ps
// package: shared types, constants and widths for the ray/sphere nearest hit block
package rsnh_pkg;

    // table depth default and field widths
    localparam int MAX_SPHERES_DEF = 64;
    localparam int CNT_W  = 7;
    localparam int DIST_W = 31;
    localparam int SLOT_W = 6;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 32;

    // datapath widths
    localparam int OPW  = 68;   // multiplier operand, signed
    localparam int PRW  = 136;  // multiplier product, signed
    localparam int AW_A = 64;   // d.d, unsigned
    localparam int DSW  = 134;  // discriminant
    localparam int SQW  = 67;   // square root
    localparam int NUMW = 70;   // h +- s, signed
    localparam int NW   = 86;   // (h +- s) * 2^16, signed
    localparam int DVW  = 95;   // divider remainder
    localparam int TW   = 31;   // quotient, Q16.16 distance

    // register indexes
    localparam logic [CFG_IW-1:0] REG_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] REG_MIN   = 2'd1;
    localparam logic [CFG_IW-1:0] REG_MAX   = 2'd2;

    // register reset values
    localparam logic [CNT_W-1:0]  COUNT_RST = 7'd0;
    localparam logic [DIST_W-1:0] MIN_RST   = 31'd66;
    localparam logic [DIST_W-1:0] MAX_RST   = 31'h7fff_ffff;

    // request op codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRACE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [5:0]         slot;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        radius;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_in_req;

    typedef struct packed {
        logic        hit;
        logic [30:0] nearest_t;
        logic [5:0]  hit_slot;
        logic        outside_hit;
    } t_out_res;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        r;
    } t_ball;

    // start strobe of an iterative unit
    typedef struct packed {
        logic start;
    } t_unit_ctl;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MSTART, ST_MWAIT, ST_ACHK, ST_READ, ST_LATCH, ST_DCHK,
        ST_SQRT_GO, ST_SQRT_WAIT, ST_ROOT, ST_DIV_WAIT, ST_NEXT, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        MOP_AX, MOP_AY, MOP_AZ, MOP_HX, MOP_HY, MOP_HZ,
        MOP_CX, MOP_CY, MOP_CZ, MOP_CR, MOP_HH, MOP_AC
    } t_mop;

endpackage

>>> rtl/rsnh_table.sv
`timescale 1ns / 1ps
// sphere table: one write port, one registered read port
module rsnh_table import rsnh_pkg::*; #(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF,
    parameter int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_ball         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_ball         o_rdata
);

    t_ball r_mem [MAX_SPHERES];
    t_ball r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rsnh_mul.sv
`timescale 1ns / 1ps
// shift-add signed multiplier, one partial product per cycle
module rsnh_mul import rsnh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_unit_ctl             i_ctl,
    input  logic signed [OPW-1:0] i_a,
    input  logic signed [OPW-1:0] i_b,
    output logic                  o_done,
    output logic signed [PRW-1:0] o_prod
);

    logic           r_busy;
    logic           r_fix;
    logic           r_done;
    logic [6:0]     r_cnt;
    logic [PRW-1:0] r_mc;
    logic [OPW-1:0] r_mp;
    logic [PRW-1:0] r_acc;
    logic           r_neg;
    logic [OPW-1:0] mag_a;
    logic [OPW-1:0] mag_b;

    // operand magnitudes
    assign mag_a = i_a[OPW-1] ? OPW'(-i_a) : OPW'(i_a);
    assign mag_b = i_b[OPW-1] ? OPW'(-i_b) : OPW'(i_b);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(OPW - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // accumulate, then apply sign
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mc  <= PRW'(mag_a);
            r_mp  <= mag_b;
            r_acc <= '0;
            r_neg <= i_a[OPW-1] ^ i_b[OPW-1];
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= {r_mc[PRW-2:0], 1'b0};
            r_mp <= {1'b0, r_mp[OPW-1:1]};
        end else if (r_fix && r_neg) begin
            r_acc <= -r_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = signed'(r_acc);

endmodule

>>> rtl/rsnh_sqrt.sv
`timescale 1ns / 1ps
// digit-by-digit integer square root, one result bit per cycle
module rsnh_sqrt import rsnh_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_unit_ctl      i_ctl,
    input  logic [DSW-1:0] i_x,
    output logic           o_done,
    output logic [SQW-1:0] o_root
);

    logic             r_busy;
    logic             r_done;
    logic [6:0]       r_cnt;
    logic [DSW-1:0]   r_x;
    logic [SQW+2:0]   r_rem;
    logic [SQW-1:0]   r_root;
    logic [SQW+2:0]   rem2;
    logic [SQW+2:0]   trial;
    logic             take;

    // one restoring step
    assign rem2  = {r_rem[SQW:0], r_x[DSW-1:DSW-2]};
    assign trial = (SQW+3)'({r_root, 2'b01});
    assign take  = (rem2 >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(SQW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[DSW-3:0], 2'b00};
            r_rem  <= take ? rem2 - trial : rem2;
            r_root <= {r_root[SQW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> rtl/rsnh_div.sv
`timescale 1ns / 1ps
// restoring divider for the Q16.16 root, one quotient bit per cycle
module rsnh_div import rsnh_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_unit_ctl       i_ctl,
    input  logic [NW-2:0]   i_num,
    input  logic [AW_A-1:0] i_den,
    output logic            o_done,
    output logic [TW-1:0]   o_quot
);

    logic           r_busy;
    logic           r_done;
    logic [4:0]     r_cnt;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_den;
    logic [TW-1:0]  r_quot;
    logic           take;

    assign take = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(TW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits from bit 30 down
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= DVW'(i_num);
            r_den  <= DVW'({i_den, 30'b0});
            r_quot <= '0;
        end else if (r_busy) begin
            if (take) begin
                r_rem <= r_rem - r_den;
            end
            r_den  <= {1'b0, r_den[DVW-1:1]};
            r_quot <= {r_quot[TW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/ray_sphere_nearest_hit.sv
`timescale 1ns / 1ps
// ray against sphere table, nearest hit, Q16.16 (top level)
// a load request is written into the table when accepted; a trace result is valid after
//   the direction products and, per tested sphere, the products on the shared shift-add
//   multiplier, the square root and each root try through the divider
// throughput: one request at a time; a result waits in an output register
// reset: synchronous active-low; clears control and config, not the sphere table
module ray_sphere_nearest_hit import rsnh_pkg::*; #(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_req           i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_res          o_out_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CW = $clog2(MAX_SPHERES + 1);

    t_state r_state, n_state;
    t_mop   r_mop;

    logic [CNT_W-1:0]  r_count;
    logic [DIST_W-1:0] r_min;
    logic [DIST_W-1:0] r_max;

    logic signed [31:0]   r_ox, r_oy, r_oz, r_dx, r_dy, r_dz;
    logic signed [32:0]   r_px, r_py, r_pz;
    logic [30:0]          r_rad;
    logic [AW_A-1:0]      r_a;
    logic signed [OPW-1:0] r_h;
    logic signed [OPW-1:0] r_c;
    logic signed [DSW-1:0] r_disc;
    logic [SQW-1:0]       r_s;
    logic                 r_far;
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_i;
    logic [DIST_W-1:0]    r_best;
    logic [CW-1:0]        r_best_slot;
    logic                 r_hit;
    logic                 r_front;
    logic                 r_out_valid;
    t_out_res             r_out;

    logic                  in_acc;
    logic                  out_free;
    logic                  load_we;
    t_ball                 wdata;
    t_ball                 rdata;
    t_unit_ctl             mul_ctl, sqrt_ctl, div_ctl;
    logic signed [OPW-1:0] mul_a, mul_b;
    logic signed [PRW-1:0] prod;
    logic                  mul_done, sqrt_done, div_done;
    logic [SQW-1:0]        sq_root;
    logic [TW-1:0]         quot;
    logic signed [NUMW-1:0] num;
    logic signed [NW-1:0]   nsh;
    logic [DVW-1:0]        bound;
    logic                  root_ok;
    logic                  in_bounds;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // sphere table
    assign load_we = in_acc && (i_in_req.op == OP_LOAD) &&
                     (32'(i_in_req.slot) < 32'(MAX_SPHERES));
    assign wdata.cx = i_in_req.center_x;
    assign wdata.cy = i_in_req.center_y;
    assign wdata.cz = i_in_req.center_z;
    assign wdata.r  = i_in_req.radius;

    rsnh_table #(.MAX_SPHERES(MAX_SPHERES), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (AW'(i_in_req.slot)),
        .i_wdata (wdata),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (rdata)
    );

    // multiplier operand select
    always_comb begin
        case (r_mop)
            MOP_AX: begin mul_a = OPW'(r_dx); mul_b = OPW'(r_dx); end
            MOP_AY: begin mul_a = OPW'(r_dy); mul_b = OPW'(r_dy); end
            MOP_AZ: begin mul_a = OPW'(r_dz); mul_b = OPW'(r_dz); end
            MOP_HX: begin mul_a = OPW'(r_dx); mul_b = OPW'(r_px); end
            MOP_HY: begin mul_a = OPW'(r_dy); mul_b = OPW'(r_py); end
            MOP_HZ: begin mul_a = OPW'(r_dz); mul_b = OPW'(r_pz); end
            MOP_CX: begin mul_a = OPW'(r_px); mul_b = OPW'(r_px); end
            MOP_CY: begin mul_a = OPW'(r_py); mul_b = OPW'(r_py); end
            MOP_CZ: begin mul_a = OPW'(r_pz); mul_b = OPW'(r_pz); end
            MOP_CR: begin
                mul_a = signed'(OPW'(r_rad));
                mul_b = signed'(OPW'(r_rad));
            end
            MOP_HH: begin mul_a = r_h; mul_b = r_h; end
            MOP_AC: begin mul_a = signed'(OPW'(r_a)); mul_b = r_c; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_ctl.start  = (r_state == ST_MSTART);
    assign sqrt_ctl.start = (r_state == ST_SQRT_GO);

    rsnh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    rsnh_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sqrt_ctl),
        .i_x     (DSW'(unsigned'(r_disc))),
        .o_done  (sqrt_done),
        .o_root  (sq_root)
    );

    // candidate root numerator and range check
    assign num     = r_far ? NUMW'(r_h) + signed'(NUMW'(r_s))
                           : NUMW'(r_h) - signed'(NUMW'(r_s));
    assign nsh     = {NW'(num)} <<< 16;
    assign bound   = DVW'({r_a, 31'b0});
    assign root_ok = !nsh[NW-1] && (DVW'(nsh[NW-2:0]) < bound);
    assign div_ctl.start = (r_state == ST_ROOT) && root_ok;

    rsnh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (nsh[NW-2:0]),
        .i_den   (r_a),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign in_bounds = (quot > r_min) && (quot < r_max);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_req.op == OP_TRACE) begin
                    n_state = ST_MSTART;
                end
            end
            ST_MSTART: n_state = ST_MWAIT;
            ST_MWAIT: begin
                if (mul_done) begin
                    if (r_mop == MOP_AZ) begin
                        n_state = ST_ACHK;
                    end else if (r_mop == MOP_AC) begin
                        n_state = ST_DCHK;
                    end else begin
                        n_state = ST_MSTART;
                    end
                end
            end
            ST_ACHK: begin
                n_state = (r_a == '0 || r_n == '0) ? ST_DONE : ST_READ;
            end
            ST_READ:  n_state = ST_LATCH;
            ST_LATCH: n_state = ST_MSTART;
            ST_DCHK: n_state = r_disc[DSW-1] ? ST_NEXT : ST_SQRT_GO;
            ST_SQRT_GO: n_state = ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_ok) begin
                    n_state = ST_DIV_WAIT;
                end else if (r_far) begin
                    n_state = ST_NEXT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (in_bounds || r_far) ? ST_NEXT : ST_ROOT;
                end
            end
            ST_NEXT: n_state = (r_i + CW'(1) == r_n) ? ST_DONE : ST_READ;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RST;
            r_min   <= MIN_RST;
            r_max   <= MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                REG_MIN:   r_min   <= i_cfg_data[DIST_W-1:0];
                REG_MAX:   r_max   <= i_cfg_data[DIST_W-1:0];
                default:   ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // trace datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ox        <= i_in_req.origin_x;
                r_oy        <= i_in_req.origin_y;
                r_oz        <= i_in_req.origin_z;
                r_dx        <= i_in_req.dir_x;
                r_dy        <= i_in_req.dir_y;
                r_dz        <= i_in_req.dir_z;
                r_mop       <= MOP_AX;
                r_best      <= r_max;
                r_best_slot <= '0;
                r_hit       <= 1'b0;
                r_front     <= 1'b0;
                r_i         <= '0;
                r_n         <= (32'(r_count) > 32'(MAX_SPHERES)) ? CW'(MAX_SPHERES)
                                                                : CW'(r_count);
            end
            ST_MWAIT: begin
                if (mul_done) begin
                    r_mop <= t_mop'(r_mop + 4'd1);
                    case (r_mop)
                        MOP_AX: r_a <= prod[AW_A-1:0];
                        MOP_AY, MOP_AZ: r_a <= r_a + prod[AW_A-1:0];
                        MOP_HX: r_h <= prod[OPW-1:0];
                        MOP_HY, MOP_HZ: r_h <= r_h + prod[OPW-1:0];
                        MOP_CX: r_c <= prod[OPW-1:0];
                        MOP_CY, MOP_CZ: r_c <= r_c + prod[OPW-1:0];
                        MOP_CR: r_c <= r_c - prod[OPW-1:0];
                        MOP_HH: r_disc <= prod[DSW-1:0];
                        MOP_AC: r_disc <= r_disc - prod[DSW-1:0];
                        default: ;
                    endcase
                end
            end
            ST_LATCH: begin
                r_px  <= 33'(rdata.cx) - 33'(r_ox);
                r_py  <= 33'(rdata.cy) - 33'(r_oy);
                r_pz  <= 33'(rdata.cz) - 33'(r_oz);
                r_rad <= rdata.r;
                r_mop <= MOP_HX;
                r_far <= 1'b0;
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    r_s <= sq_root;
                end
            end
            ST_ROOT: begin
                if (!root_ok) begin
                    r_far <= 1'b1;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (in_bounds) begin
                        if (quot < r_best) begin
                            r_best      <= quot;
                            r_best_slot <= r_i;
                            r_hit       <= 1'b1;
                            r_front     <= !r_far && (r_disc != '0);
                        end
                    end else begin
                        r_far <= 1'b1;
                    end
                end
            end
            ST_NEXT: begin
                r_i <= r_i + CW'(1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out.hit         <= r_hit;
            r_out.nearest_t   <= r_best;
            r_out.hit_slot    <= r_hit ? 6'(r_best_slot) : 6'd0;
            r_out.outside_hit <= r_hit && r_front;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// testbench for ray_sphere_nearest_hit: exact-integer hit scoreboard, directed and random traffic
module tb_top;
    import rsnh_pkg::*;

    // register index with no register behind it
    localparam logic [CFG_IW-1:0] REG_NONE = 2'd3;

    // expected-result store and nearest-hit predictor
    class hit_scoreboard;
        t_ball       spheres[64];
        int unsigned n_spheres;
        longint     lo_dist;
        longint     hi_dist;
        t_out_res   pending[$];
        int         errors;

        function new();
            n_spheres = 0;
            lo_dist   = 66;
            hi_dist   = 64'h7fff_ffff;
            errors    = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
            case (idx)
                REG_COUNT: n_spheres = 32'(d[6:0]);
                REG_MIN:   lo_dist   = longint'(d[30:0]);
                REG_MAX:   hi_dist   = longint'(d[30:0]);
                default: ;
            endcase
        endfunction

        // floor(num * 2^16 / a), accepted only inside the open distance window
        function bit root_dist(logic signed [199:0] num, logic signed [199:0] a,
                               output longint t);
            logic signed [199:0] n;
            logic signed [199:0] lim;
            n   = num * 65536;
            lim = a <<< 31;
            t   = 0;
            if (n < 0 || n >= lim) return 0;
            t = longint'(n / a);
            return (t > lo_dist && t < hi_dist);
        endfunction

        function t_out_res nearest_hit(t_in_req q);
            logic signed [199:0] dx, dy, dz, a, px, py, pz, h, c, disc, s, cand, rr;
            longint      best, t;
            int unsigned n, i;
            int          b;
            bit          found, ff, front;
            int          bslot;
            t_out_res    res;
            dx = 200'(q.dir_x); dy = 200'(q.dir_y); dz = 200'(q.dir_z);
            a = dx * dx + dy * dy + dz * dz;
            best = hi_dist; found = 0; front = 0; bslot = 0;
            n = (n_spheres > 64) ? 64 : n_spheres;
            if (a != 0) begin
                for (i = 0; i < n; i++) begin
                    px = 200'(spheres[i].cx); px = px - 200'(q.origin_x);
                    py = 200'(spheres[i].cy); py = py - 200'(q.origin_y);
                    pz = 200'(spheres[i].cz); pz = pz - 200'(q.origin_z);
                    rr = 200'(spheres[i].r);
                    h = dx * px + dy * py + dz * pz;
                    c = px * px + py * py + pz * pz - rr * rr;
                    disc = h * h - a * c;
                    if (disc < 0) continue;
                    // bitwise integer square root
                    s = 0;
                    for (b = 66; b >= 0; b--) begin
                        cand = s;
                        cand[b] = 1'b1;
                        if (!(disc < cand * cand)) s = cand;
                    end
                    if (root_dist(h - s, a, t)) ff = (disc != 0);
                    else if (root_dist(h + s, a, t)) ff = 0;
                    else continue;
                    if (t < best) begin
                        best = t; bslot = i; front = ff; found = 1;
                    end
                end
            end
            res.hit         = found;
            res.nearest_t   = best[30:0];
            res.hit_slot    = found ? bslot[5:0] : 6'd0;
            res.outside_hit = found && front;
            return res;
        endfunction

        function void note_request(t_in_req q);
            if (q.op == OP_LOAD) begin
                spheres[q.slot] = '{q.center_x, q.center_y, q.center_z, q.radius};
            end else begin
                pending.push_back(nearest_hit(q));
            end
        endfunction

        task check_result(t_out_res r);
            t_out_res e;
            if (pending.size() == 0) begin
                report("result with no trace outstanding");
                return;
            end
            e = pending.pop_front();
            if (r.hit !== e.hit)
                report($sformatf("hit got %0b exp %0b", r.hit, e.hit));
            if (r.nearest_t !== e.nearest_t)
                report($sformatf("nearest_t got %0h exp %0h", r.nearest_t,
                                 e.nearest_t));
            if (r.hit_slot !== e.hit_slot)
                report($sformatf("hit_slot got %0d exp %0d", r.hit_slot, e.hit_slot));
            if (r.outside_hit !== e.outside_hit)
                report($sformatf("outside_hit got %0b exp %0b", r.outside_hit,
                                 e.outside_hit));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_req           i_in_req = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_res          o_out_res;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    hit_scoreboard sb = new();
    bit            calm;
    bit            written[64];
    int            cen[64][3];
    int            n_sent;

    ray_sphere_nearest_hit u_dut (.*);

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("Some tests failed");
        $finish;
    end

    function int gap();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // result side: random stalls, then take and check one result
    initial begin
        @(posedge i_rst_n);
        forever begin
            repeat (gap()) begin
                @(negedge i_clk) i_out_stall = 1'b1;
            end
            @(negedge i_clk) i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_out_res);
        end
    end

    task send_req(t_in_req q);
        repeat (gap()) begin
            @(negedge i_clk) i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_req   = q;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(q);
        if (q.op == OP_LOAD) begin
            written[q.slot] = 1;
            cen[q.slot][0] = q.center_x;
            cen[q.slot][1] = q.center_y;
            cen[q.slot][2] = q.center_z;
        end
        n_sent++;
    endtask

    // hold off until every trace has returned and the block is quiet
    task wait_idle();
        @(negedge i_clk) i_in_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
        @(negedge i_clk) i_cfg_valid = 1'b0;
    endtask

    function t_in_req rand_req();
        t_in_req      r;
        logic [383:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(t_in_req)-1:0];
        return r;
    endfunction

    function int near_val(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function t_in_req mk_load(int slot);
        t_in_req r;
        r = rand_req();
        r.op = OP_LOAD;
        r.slot = 6'(slot);
        if ($urandom_range(0, 99) < 85) begin
            r.center_x = near_val(20 << 16);
            r.center_y = near_val(20 << 16);
            r.center_z = near_val(20 << 16);
            r.radius   = 31'($urandom_range(32'h0000_4000, 32'h0005_0000));
        end
        return r;
    endfunction

    function t_in_req mk_trace();
        t_in_req r;
        int      k, sh;
        r = rand_req();
        r.op = OP_TRACE;
        k = $urandom_range(0, 63);
        if ($urandom_range(0, 19) == 0) begin
            r.dir_x = 0; r.dir_y = 0; r.dir_z = 0;
        end else if ($urandom_range(0, 99) < 85 && written[k]) begin
            // aim the ray near a loaded sphere center
            sh = $urandom_range(0, 6);
            r.origin_x = near_val(5 << 16);
            r.origin_y = near_val(5 << 16);
            r.origin_z = near_val(5 << 16);
            r.dir_x = (cen[k][0] + near_val(1 << 16) - r.origin_x) >>> sh;
            r.dir_y = (cen[k][1] + near_val(1 << 16) - r.origin_y) >>> sh;
            r.dir_z = (cen[k][2] + near_val(1 << 16) - r.origin_z) >>> sh;
        end
        return r;
    endfunction

    function int written_prefix();
        int k;
        for (k = 0; k < 64; k++)
            if (!written[k]) return k;
        return 64;
    endfunction

    function t_in_req ball_at(int slot, int x, int y, int z, int r);
        t_in_req q;
        q = rand_req();
        q.op = OP_LOAD; q.slot = 6'(slot);
        q.center_x = x; q.center_y = y; q.center_z = z; q.radius = 31'(r);
        return q;
    endfunction

    function t_in_req ray(int ox, int oy, int oz, int dx, int dy, int dz);
        t_in_req q;
        q = rand_req();
        q.op = OP_TRACE;
        q.origin_x = ox; q.origin_y = oy; q.origin_z = oz;
        q.dir_x = dx; q.dir_y = dy; q.dir_z = dz;
        return q;
    endfunction

    // stimulus
    initial begin
        int          p, k, cnt, pref, lim;
        logic [30:0] lo, hi;
        n_sent = 0;
        calm = 1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed: tie, inside hit, tangent, miss, zero direction, extreme fields
        send_req(ball_at(0, 0, 0, 10 << 16, 1 << 16));
        send_req(ball_at(1, 0, 0, 10 << 16, 1 << 16));
        send_req(ball_at(2, 0, 0, 5 << 16, 1 << 16));
        send_req(ball_at(3, 0, 0, 0, 3 << 16));
        send_req(ray(0, 0, 0, 0, 0, 1 << 16));   // count still 0
        wait_idle();
        cfg_write(REG_COUNT, 4);
        cfg_write(REG_NONE, 32'hffff_ffff);      // unused index, ignored
        send_req(ray(0, 0, 0, 0, 0, 1 << 16));
        send_req(ray(0, 0, 0, 0, 0, -(1 << 16)));
        send_req(ray(1 << 16, 0, -(20 << 16), 0, 0, 1 << 16));
        send_req(ray(0, 5 << 16, 0, 1 << 16, 0, 0));
        send_req(ray(0, 0, 0, 0, 0, 0));
        send_req(ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        send_req(ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        send_req(ball_at(2, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        send_req(ray(0, 0, 0, 1 << 16, 1 << 16, 1 << 16));
        send_req(ball_at(2, 0, 0, 10 << 16, 1 << 16));
        send_req(ray(0, 0, 0, 0, 0, 1 << 16));
        wait_idle();
        cfg_write(REG_MIN, 0);
        cfg_write(REG_MAX, 0);
        send_req(ray(0, 0, 0, 0, 0, 1 << 16));
        wait_idle();
        cfg_write(REG_MIN, 32'h7fff_ffff);
        cfg_write(REG_MAX, 32'h7fff_ffff);
        send_req(ray(0, 0, 0, 0, 0, 1 << 16));

        // random phases over several register settings
        p = 0;
        while (n_sent < 1650) begin
            wait_idle();
            calm = ($urandom_range(0, 3) == 0);
            case (p % 6)
                0: begin lo = '0; hi = 31'h7fff_ffff; end
                1: begin lo = 31'($urandom_range(0, 32'h0010_0000)); hi = lo; end
                2: begin hi = 31'($urandom_range(0, 32'h0010_0000)); lo = hi + 31'd5; end
                3: begin lo = 31'($urandom_range(0, 32'h0002_0000));
                         hi = 31'($urandom_range(32'h0002_0000, 32'h0020_0000)); end
                4: begin lo = '0; hi = '0; end
                default: begin lo = 31'd66; hi = 31'($urandom & 32'h7fff_ffff); end
            endcase
            if (p == 9) begin
                // full table, count above the table size
                for (k = 0; k < 64; k++) send_req(mk_load(k));
                wait_idle();
                cfg_write(REG_COUNT, 127);
                cfg_write(REG_MIN, 66);
                cfg_write(REG_MAX, 32'h7fff_ffff);
                for (k = 0; k < 3; k++) send_req(mk_trace());
                wait_idle();
                cfg_write(REG_COUNT, 64);
                send_req(mk_trace());
                p++;
                continue;
            end
            pref = written_prefix();
            lim  = (pref < 2) ? pref : 2;
            cnt  = $urandom_range(0, lim);
            cfg_write(REG_COUNT, cnt);
            cfg_write(REG_MIN, 32'(lo));
            cfg_write(REG_MAX, 32'(hi));
            for (k = 0; k < 40; k++) begin
                if (k == 20 && p == 2) wait_idle();
                if ($urandom_range(0, 99) < 60)
                    send_req(mk_load(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                                : $urandom_range(0, 7)));
                else
                    send_req(mk_trace());
            end
            p++;
        end

        // drain
        @(negedge i_clk) i_in_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
